/* design/iai_pkg.sv */
`timescale 1ns / 1ps

package iai_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int FILL_W = 7;
    localparam int ERR_W  = 2;
    // index width covering the largest supported depth (1024) and the position field
    localparam int IDX_W  = 11;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND    = 3'd0,
        ACT_DROP_LAST = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_REMOVE    = 3'd3,
        ACT_OVERWRITE = 3'd4,
        ACT_READ      = 3'd5,
        ACT_CLEAR     = 3'd6
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_EMPTY = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;
    } t_cell_cmd;

endpackage

/* design/iai_cell.sv */
`timescale 1ns / 1ps

module iai_cell
    import iai_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_data,
    input  logic signed [DATA_W-1:0] i_prev,
    input  logic signed [DATA_W-1:0] i_next,
    output logic signed [DATA_W-1:0] o_value,
    output logic signed [DATA_W-1:0] o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     w_hit;
    logic                     w_above;

    assign w_hit   = (i_cmd.idx == MY_IDX);
    assign w_above = (MY_IDX > i_cmd.idx);

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_WRITE: begin
                if (w_hit) n_value = i_data;
            end
            CELL_INSERT: begin
                if (w_hit) n_value = i_data;
                else if (w_above) n_value = i_prev;
            end
            CELL_REMOVE: begin
                if (w_hit || w_above) n_value = i_next;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = w_hit ? r_value : '0;

endmodule

/* design/iai_ctrl.sv */
`timescale 1ns / 1ps

module iai_ctrl
    import iai_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_rd_data,
    output t_cell_cmd                o_cmd,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [FILL_W-1:0]        o_fill_count,
    output logic                     o_is_empty,
    output logic [ERR_W-1:0]         o_error_code
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_read_value;
    logic [CNT_W-1:0]         r_res_count;
    logic                     r_is_empty;
    t_err                     r_err;

    t_err                     w_err;
    t_cell_op                 w_op;
    logic [IDX_W-1:0]         w_idx;
    logic                     w_rd_sel;
    logic [IDX_W-1:0]         w_pos_x;
    logic [IDX_W-1:0]         w_cnt_x;
    logic                     w_full;
    logic                     w_empty;

    assign w_pos_x = IDX_W'(i_position);
    assign w_cnt_x = IDX_W'(r_count);
    assign w_full  = (w_cnt_x == IDX_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_count  = r_count;
        w_err    = ERR_OK;
        w_op     = CELL_HOLD;
        w_idx    = w_pos_x;
        w_rd_sel = 1'b0;
        unique case (i_action)
            ACT_APPEND: begin
                if (w_full) begin
                    w_err = ERR_FULL;
                end else begin
                    w_op    = CELL_WRITE;
                    w_idx   = w_cnt_x;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_DROP_LAST: begin
                if (w_empty) w_err = ERR_EMPTY;
                else n_count = r_count - CNT_W'(1);
            end
            ACT_INSERT: begin
                priority if (w_pos_x > w_cnt_x) begin
                    w_err = ERR_RANGE;
                end else if (w_full) begin
                    w_err = ERR_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                priority if (w_empty) begin
                    w_err = ERR_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_err = ERR_RANGE;
                end else begin
                    w_op    = CELL_REMOVE;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_OVERWRITE: begin
                if (w_pos_x >= w_cnt_x) w_err = ERR_RANGE;
                else w_op = CELL_WRITE;
            end
            ACT_READ: begin
                if (w_pos_x >= w_cnt_x) w_err = ERR_RANGE;
                else w_rd_sel = 1'b1;
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_cmd.op  = i_start ? w_op : CELL_HOLD;
    assign o_cmd.idx = w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
            if (i_start) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_read_value <= w_rd_sel ? i_rd_data : '0;
            r_res_count  <= n_count;
            r_is_empty   <= (n_count == '0);
            r_err        <= w_err;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_fill_count = FILL_W'(r_res_count);
    assign o_is_empty   = r_is_empty;
    assign o_error_code = r_err;

endmodule

/* design/indexed_array_insert_remove.sv */
`timescale 1ns / 1ps
// The result beat appears in the cycle after start is taken, marked by o_valid.
// Throughput: one request per cycle; the affected cells of the chain shift or load in that
// same cycle, and busy never rises.
// Reset (synchronous, active low) empties the array and drops o_valid; cell
// contents are left as they are.
module indexed_array_insert_remove
    import iai_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_data_value,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [FILL_W-1:0]        o_fill_count,
    output logic                     o_is_empty,
    output logic [ERR_W-1:0]         o_error_code
);

    t_cell_cmd                w_cmd;
    logic                     w_accept;
    logic signed [DATA_W-1:0] w_val [DEPTH];
    logic signed [DATA_W-1:0] w_tap [DEPTH];
    logic signed [DATA_W-1:0] w_rd_data;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    iai_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_rd_data   (w_rd_data),
        .o_cmd       (w_cmd),
        .o_valid     (o_valid),
        .o_read_value(o_read_value),
        .o_fill_count(o_fill_count),
        .o_is_empty  (o_is_empty),
        .o_error_code(o_error_code)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_data_value;
        end else begin : g_mid
            assign w_prev = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end

        iai_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_data (i_data_value),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_value(w_val[g]),
            .o_tap  (w_tap[g])
        );
    end

    // at most one tap is nonzero
    always_comb begin
        w_rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_data = w_rd_data | w_tap[i];
        end
    end

    a_valid_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == $past(w_accept && i_rst_n))
        else $error("result beat does not match accepted request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_FULL) |-> o_fill_count == FILL_W'(DEPTH))
        else $error("full error with array not full");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_OK) |-> o_read_value == '0)
        else $error("read data on failed request");

    a_empty_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_EMPTY) |-> o_is_empty)
        else $error("empty error with entries present");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import iai_pkg::*;

    localparam int DEPTH          = 64;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } t_ph_mode;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        t_err                     error_code;
    } t_outcome;

    class array_scoreboard;
        logic signed [DATA_W-1:0] cells [DEPTH];
        int       fill;
        int       peak_fill;
        int       errors;
        int       checked;
        int       code_hist [4];
        t_outcome outcomes [$];

        function new();
            foreach (cells[i]) cells[i] = '0;
            foreach (code_hist[i]) code_hist[i] = 0;
            fill      = 0;
            peak_fill = 0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos_in,
                                   logic signed [DATA_W-1:0] val);
            t_outcome o;
            int       pos;
            pos          = int'(pos_in);
            o.read_value = '0;
            o.error_code = ERR_OK;
            case (act)
                ACT_APPEND: begin
                    if (fill >= DEPTH) begin
                        o.error_code = ERR_FULL;
                    end else begin
                        cells[fill] = val;
                        fill++;
                    end
                end
                ACT_DROP_LAST: begin
                    if (fill == 0) o.error_code = ERR_EMPTY;
                    else fill--;
                end
                ACT_INSERT: begin
                    if (pos > fill) begin
                        o.error_code = ERR_RANGE;
                    end else if (fill >= DEPTH) begin
                        o.error_code = ERR_FULL;
                    end else begin
                        for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                        cells[pos] = val;
                        fill++;
                    end
                end
                ACT_REMOVE: begin
                    if (fill == 0) begin
                        o.error_code = ERR_EMPTY;
                    end else if (pos >= fill) begin
                        o.error_code = ERR_RANGE;
                    end else begin
                        for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                    end
                end
                ACT_OVERWRITE: begin
                    if (pos >= fill) o.error_code = ERR_RANGE;
                    else cells[pos] = val;
                end
                ACT_READ: begin
                    if (pos >= fill) o.error_code = ERR_RANGE;
                    else o.read_value = cells[pos];
                end
                ACT_CLEAR: begin
                    fill = 0;
                end
                default: begin
                end
            endcase
            if (fill > peak_fill) peak_fill = fill;
            o.fill_count = FILL_W'(fill);
            o.is_empty   = (fill == 0);
            outcomes.insert(outcomes.size(), o);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] rd, logic [FILL_W-1:0] cnt,
                                   logic empty, logic [ERR_W-1:0] err);
            t_outcome o;
            if (outcomes.size() == 0) begin
                $display("%0t: result beat with nothing pending (read %0d, fill %0d, err %0d)",
                         $time, rd, cnt, err);
                errors++;
                return;
            end
            o = outcomes.pop_front();
            checked++;
            code_hist[o.error_code]++;
            if (rd !== o.read_value) begin
                $display("%0t: read_value expected %0d, actual %0d", $time, o.read_value, rd);
                errors++;
            end
            if (cnt !== o.fill_count) begin
                $display("%0t: fill_count expected %0d, actual %0d", $time, o.fill_count, cnt);
                errors++;
            end
            if (empty !== o.is_empty) begin
                $display("%0t: is_empty expected %0d, actual %0d", $time, o.is_empty, empty);
                errors++;
            end
            if (err !== o.error_code) begin
                $display("%0t: error_code expected %0d, actual %0d", $time, o.error_code, err);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [ACT_W-1:0]         i_action;
    logic [POS_W-1:0]         i_position;
    logic signed [DATA_W-1:0] i_data_value;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_read_value;
    logic [FILL_W-1:0]        o_fill_count;
    logic                     o_is_empty;
    logic [ERR_W-1:0]         o_error_code;

    array_scoreboard sb;
    int              accepted;
    int              idle_cycles;

    indexed_array_insert_remove #(.DEPTH(DEPTH)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_position   (i_position),
        .i_data_value (i_data_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_fill_count (o_fill_count),
        .o_is_empty   (o_is_empty),
        .o_error_code (o_error_code)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        bit got_beat;
        got_beat = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                sb.check_result(o_read_value, o_fill_count, o_is_empty, o_error_code);
                got_beat = 1'b1;
            end
            if (start && !busy) begin
                sb.note_request(i_action, i_position, i_data_value);
                accepted++;
                got_beat = 1'b1;
            end
            idle_cycles = got_beat ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results pending",
                         $time, sb.outcomes.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // called and returns at a falling edge
    task automatic issue(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                         logic signed [DATA_W-1:0] val);
        start        <= 1'b1;
        i_action     <= act;
        i_position   <= pos;
        i_data_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.outcomes.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int                       n_items;
        int                       burst_left;
        int                       phase_left;
        int                       phase_count;
        int                       roll;
        int                       lim;
        t_ph_mode                 mode;
        logic [ACT_W-1:0]         act;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        sb           = new();
        accepted     = 0;
        idle_cycles  = 0;
        start        = 1'b0;
        i_action     = '0;
        i_position   = '0;
        i_data_value = '0;
        i_rst_n      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty-array corner cases, then directed requests on a small filled array
        issue(ACT_READ,      7'd0, 32'sd0);
        issue(ACT_DROP_LAST, 7'd0, 32'sd0);
        issue(ACT_REMOVE,    7'd0, 32'sd0);
        issue(ACT_OVERWRITE, 7'd0, 32'sd5);
        issue(ACT_INSERT,    7'd1, 32'sd9);
        issue(ACT_INSERT,    7'd0, 32'sh7FFFFFFF);
        issue(ACT_APPEND,    7'd0, 32'sh80000000);
        issue(ACT_APPEND,    7'd0, 32'sd0);
        issue(ACT_APPEND,    7'd0, -32'sd1);
        issue(ACT_INSERT,    7'd2, 32'sh5A5A5A5A);
        issue(ACT_INSERT,    7'd5, 32'sh12345678);
        issue(ACT_INSERT,    7'd7, 32'sd3);
        issue(ACT_READ,      7'd2, 32'sd0);
        issue(ACT_READ,      7'd5, 32'sd0);
        issue(ACT_READ,      7'd6, 32'sd0);
        issue(ACT_READ,      7'd127, 32'sd0);
        issue(ACT_REMOVE,    7'd0, 32'sd0);
        issue(ACT_REMOVE,    7'd4, 32'sd0);
        issue(ACT_REMOVE,    7'd4, 32'sd0);
        issue(ACT_OVERWRITE, 7'd3, 32'shA5A5A5A5);
        issue(ACT_OVERWRITE, 7'd64, 32'sd1);
        issue(ACT_READ,      7'd3, 32'sd0);
        issue(ACT_UNUSED,    7'd0, 32'sd77);
        issue(ACT_DROP_LAST, 7'd0, 32'sd0);
        issue(ACT_CLEAR,     7'd0, 32'sd0);
        issue(ACT_READ,      7'd0, 32'sd0);
        drain();

        n_items     = 0;
        burst_left  = 0;
        phase_left  = 0;
        phase_count = 0;
        mode        = PH_GROW;
        while (n_items < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_count++;
                if (phase_count % 5 == 0) drain();
                mode       = t_ph_mode'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 120);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 60);
                if ($urandom_range(0, 3) != 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge i_clk);
                end
            end

            roll = $urandom_range(0, 99);
            case (mode)
                PH_GROW:
                    act = (roll < 55) ? ACT_APPEND : (roll < 85) ? ACT_INSERT :
                          (roll < 93) ? ACT_READ : ACT_OVERWRITE;
                PH_SHRINK:
                    act = (roll < 40) ? ACT_DROP_LAST : (roll < 80) ? ACT_REMOVE :
                          (roll < 90) ? ACT_READ : ACT_OVERWRITE;
                default:
                    act = (roll < 20) ? ACT_APPEND : (roll < 30) ? ACT_DROP_LAST :
                          (roll < 50) ? ACT_INSERT : (roll < 65) ? ACT_REMOVE :
                          (roll < 77) ? ACT_OVERWRITE : (roll < 95) ? ACT_READ :
                          (roll < 97) ? ACT_CLEAR : ACT_UNUSED;
            endcase

            lim  = (act == ACT_INSERT) ? sb.fill : ((sb.fill > 0) ? sb.fill - 1 : 0);
            roll = $urandom_range(0, 99);
            if (roll < 70)      pos = POS_W'($urandom_range(0, lim));
            else if (roll < 78) pos = POS_W'(sb.fill);
            else if (roll < 85) pos = POS_W'(lim);
            else if (roll < 96) pos = POS_W'($urandom_range(0, DEPTH));
            else                pos = POS_W'($urandom_range(0, 127));

            case ($urandom_range(0, 9))
                0:       val = 32'sh80000000;
                1:       val = 32'sh7FFFFFFF;
                2:       val = 32'sd0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase

            issue(act, pos, val);
            if (act != ACT_UNUSED) n_items++;
            burst_left--;
            phase_left--;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.outcomes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.outcomes.size());
            sb.errors++;
        end

        $display("Covered %0d requests, %0d results checked, peak fill %0d of %0d.",
                 accepted, sb.checked, sb.peak_fill, DEPTH);
        $display("Outcomes: ok %0d, full %0d, bad position %0d, empty %0d.",
                 sb.code_hist[ERR_OK], sb.code_hist[ERR_FULL],
                 sb.code_hist[ERR_RANGE], sb.code_hist[ERR_EMPTY]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
